// File: rtl/bounded_deque_with_remove_macros.svh
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Concurrent assertion shorthands used by the deque top module.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Field widths, operation and status codes, the cell control word and states.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT_IN,
        CMD_APPEND,
        CMD_SHIFT_OUT,
        CMD_DROP_LAST,
        CMD_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [DATA_W-1:0]  value;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

endpackage

// File: rtl/bdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque channels
// Valid/ready request and response channels of the deque.
// ----------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [DATA_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count;
    logic [DATA_W-1:0]    front_value;
    logic [DATA_W-1:0]    back_value;

    modport source (output valid, output status, output count, output front_value,
                    output back_value, input ready);
    modport sink   (input valid, input status, input count, input front_value,
                    input back_value, output ready);
endinterface

// File: rtl/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque cell
// One list position: holds an entry and its occupancy, shifts with neighbours.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [DATA_W-1:0]  i_left_value,
    input  logic               i_left_valid,
    input  logic [DATA_W-1:0]  i_right_value,
    input  logic               i_right_valid,
    input  logic               i_found,
    input  logic [DATA_W-1:0]  i_back,
    output logic [DATA_W-1:0]  o_value,
    output logic               o_valid,
    output logic               o_found,
    output logic [DATA_W-1:0]  o_back
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              r_valid;
    logic              n_valid;
    logic              w_match;
    logic              w_last;

    assign w_match = r_valid && (r_value == i_ctl.value);
    assign w_last  = r_valid && !i_right_valid;
    assign o_found = i_found | w_match;
    assign o_back  = i_back | (w_last ? r_value : '0);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
            end
            CMD_SHIFT_IN: begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
            CMD_APPEND: begin
                if (!r_valid && i_left_valid) begin
                    n_value = i_ctl.value;
                    n_valid = 1'b1;
                end
            end
            CMD_SHIFT_OUT: begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
            CMD_DROP_LAST: begin
                if (w_last) begin
                    n_valid = 1'b0;
                end
            end
            CMD_REMOVE: begin
                // close the gap at and after the first match
                if (o_found) begin
                    n_value = i_right_value;
                    n_valid = i_right_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// File: rtl/bounded_deque_with_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with remove
// Double-ended list of unsigned words with delete of the first matching entry.
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  i_req    in   sink     op, value
//  o_rsp    out  source   status, count, front_value, back_value
//
//  Per transaction, the cell row updates on the accept edge; the load state
//  then loads the response register from the row.
//  A new request is accepted while the previous response waits in o_rsp.
//  Reset clears the count and every occupancy bit; entry data is not reset.
//  A stalled response holds the block in its load cycle, no request is taken.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_remove_macros.svh"

module bounded_deque_with_remove import bdq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bdq_in_if.sink        i_req,
    bdq_out_if.source     o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_status             r_status;
    t_status             n_status;
    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic                w_load;
    logic                w_full;
    logic                w_empty;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_count;
    logic [DATA_W-1:0]   r_out_front;
    logic [DATA_W-1:0]   r_out_back;

    logic [DATA_W-1:0]   w_value [CAPACITY];
    logic                w_valid [CAPACITY];
    logic                w_found [CAPACITY];
    logic [DATA_W-1:0]   w_back  [CAPACITY];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = w_valid[CAPACITY-1];
    assign w_empty     = !w_valid[0];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_lv;
            logic              w_lvld;
            logic [DATA_W-1:0] w_rv;
            logic              w_rvld;
            logic              w_fin;
            logic [DATA_W-1:0] w_bin;

            if (g == 0) begin : g_head
                assign w_lv   = i_req.value;
                assign w_lvld = 1'b1;
                assign w_fin  = 1'b0;
                assign w_bin  = '0;
            end else begin : g_body
                assign w_lv   = w_value[g-1];
                assign w_lvld = w_valid[g-1];
                assign w_fin  = w_found[g-1];
                assign w_bin  = w_back[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_rv   = '0;
                assign w_rvld = 1'b0;
            end else begin : g_inner
                assign w_rv   = w_value[g+1];
                assign w_rvld = w_valid[g+1];
            end

            bdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvld),
                .i_right_value (w_rv),
                .i_right_valid (w_rvld),
                .i_found       (w_fin),
                .i_back        (w_bin),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_found       (w_found[g]),
                .o_back        (w_back[g])
            );
        end
    endgenerate

    // decode the request into a row command, next count and status
    always_comb begin
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.value = i_req.value;
        n_count     = r_count;
        n_status    = r_status;
        if (w_accept) begin
            unique case (i_req.op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        w_ctl.cmd = (i_req.op == OP_PUSH_FRONT) ? CMD_SHIFT_IN : CMD_APPEND;
                        n_count   = r_count + CNT_W'(1);
                        n_status  = STATUS_DONE;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (w_empty) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        w_ctl.cmd = (i_req.op == OP_POP_FRONT) ? CMD_SHIFT_OUT : CMD_DROP_LAST;
                        n_count   = r_count - CNT_W'(1);
                        n_status  = STATUS_DONE;
                    end
                end
                OP_REMOVE: begin
                    w_ctl.cmd = CMD_REMOVE;
                    if (w_found[CAPACITY-1]) begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = STATUS_DONE;
                    end else begin
                        n_status = STATUS_EMPTY;
                    end
                end
                default: begin
                    n_status = STATUS_EMPTY;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= STATUS_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_front  <= w_valid[0] ? w_value[0] : '0;
            r_out_back   <= w_back[CAPACITY-1];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.count       = COUNT_W'(r_out_count);
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.back_value  = r_out_back;

    `BDQ_ASSERT_IMPL(a_head_occupancy, i_clk, i_rst_n, 1'b1, w_valid[0] == (r_count != '0), "head cell occupancy disagrees with count")
    `BDQ_ASSERT_IMPL(a_tail_occupancy, i_clk, i_rst_n, 1'b1, w_full == (r_count == CNT_W'(CAPACITY)), "tail cell occupancy disagrees with count")
    `BDQ_ASSERT_IMPL(a_full_status, i_clk, i_rst_n, (r_state == S_LOAD) && (r_status == STATUS_FULL), r_count == CNT_W'(CAPACITY), "insert dropped below capacity")
    `BDQ_ASSERT_NEXT(a_load_follows, i_clk, i_rst_n, w_accept, (r_state == S_LOAD) && (r_count == $past(n_count)), "accepted transaction not followed by load")

endmodule
